// ===== src/lav_pkg.sv =====
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, constants, types and arithmetic helpers of the look-at
// view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  // fixed-point format and derived widths
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int U_W        = FRAC_BITS + 2;        // unit vector component
  localparam int U2_W       = FRAC_BITS + 3;        // rounded up2 component
  localparam int UD_W       = U_W + DATA_W;         // unit * data product
  localparam int UU_W       = 2 * U_W;              // unit * unit product
  localparam int U2D_W      = U2_W + DATA_W;        // up2 * data product
  localparam int V_W        = UD_W + 1;             // raw vector component
  localparam int DOT_W      = U2D_W + 2;            // dot sums and rounding
  localparam int MAG_W      = 31;                   // normalized magnitude
  localparam int SQ_W       = 2 * MAG_W + 2;        // sum of squares
  localparam int LEN_W      = SQ_W / 2;             // vector length
  localparam int NUM_W      = LEN_W + FRAC_BITS;    // dividend
  localparam int Q_W        = FRAC_BITS + 1;        // quotient
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int POS_W      = $clog2(V_W);
  localparam int PASS_W     = 6 * DATA_W;

  // row codes and fixed values
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd3;
  localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DOT_W-1:0] SAT_MAX = DOT_W'(32'sh7fffffff);
  localparam logic signed [DOT_W-1:0] SAT_MIN = DOT_W'(32'sh80000000);

  typedef logic [2:0][V_W-1:0]    lav_vec3_t;
  typedef logic [2:0][U_W-1:0]    lav_unit3_t;
  typedef logic [2:0][DATA_W-1:0] lav_data3_t;

  // sideband that travels with an item through the normalize unit
  typedef struct packed {
    logic              vld;
    logic              zero;
    logic [2:0]        neg;
    logic [PASS_W-1:0] pass;
  } lav_tag_t;

  // passenger of the forward normalize unit
  typedef struct packed {
    lav_data3_t up;
    lav_data3_t eye;
  } lav_p1_t;

  // passenger of the side normalize unit
  typedef struct packed {
    logic       z1;
    lav_unit3_t fwd;
    lav_data3_t eye;
  } lav_p2_t;

  // index of the highest set bit
  function automatic logic [POS_W-1:0] lead_pos(logic [V_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < V_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  function automatic logic signed [UD_W-1:0] mul_ud(logic signed [U_W-1:0] a,
                                                    logic signed [DATA_W-1:0] b);
    return a * b;
  endfunction

  function automatic logic signed [UU_W-1:0] mul_uu(logic signed [U_W-1:0] a,
                                                    logic signed [U_W-1:0] b);
    return a * b;
  endfunction

  function automatic logic signed [U2D_W-1:0] mul_u2d(logic signed [U2_W-1:0] a,
                                                      logic signed [DATA_W-1:0] b);
    return a * b;
  endfunction

  // shift right by the fraction width, rounding half away from zero
  function automatic logic signed [DOT_W-1:0] shr_round(logic signed [DOT_W-1:0] v);
    logic [DOT_W-1:0] m;
    m = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
    m = (m + (DOT_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[DOT_W-1] ? -$signed(m) : $signed(m);
  endfunction

  // clamp to the signed data range
  function automatic logic [DATA_W-1:0] sat_data(logic signed [DOT_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SAT_MAX) r = 32'h7fffffff;
    else if (v < SAT_MIN) r = 32'h80000000;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

// ===== src/lav_unit.sv =====
// ----------------------------------------------------------------------------
// lav_unit
// Pipelined vector normalize: block scaling, squares, restoring square root
// one bit per stage, then three lane restoring divide one bit per stage.
// ----------------------------------------------------------------------------
module lav_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  lav_pkg::lav_vec3_t         vec_i,
  input  logic [lav_pkg::PASS_W-1:0] pass_i,
  output logic                       valid_o,
  output lav_pkg::lav_unit3_t        unit_o,
  output logic                       zero_o,
  output logic [lav_pkg::PASS_W-1:0] pass_o
);
  import lav_pkg::*;

  lav_tag_t                  s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q, s5_tag_q;
  lav_tag_t                  s1_tag_d, s2_tag_d;
  logic [2:0][V_W-1:0]       s1_mag_q, s2_mag_q, s1_mag_d;
  logic [V_W-1:0]            s1_or;
  logic [POS_W-1:0]          s2_pos_q;
  logic [2:0][MAG_W-1:0]     s3_mag_q, s4_mag_q, s5_mag_q, s3_mag_d;
  logic [2:0][2*MAG_W-1:0]   s4_sq_q;
  logic [SQ_W-1:0]           s5_sum_q;

  lav_tag_t                  rt_tag_q [ROOT_STEPS];
  lav_tag_t                  rt_tag_in [ROOT_STEPS];
  logic [SQ_W-1:0]           rt_x_q [ROOT_STEPS], rt_r_q [ROOT_STEPS];
  logic [SQ_W-1:0]           rt_xin [ROOT_STEPS], rt_rin [ROOT_STEPS];
  logic [SQ_W-1:0]           rt_x_d [ROOT_STEPS], rt_r_d [ROOT_STEPS];
  logic [SQ_W:0]             rt_trial [ROOT_STEPS];
  logic [2:0][MAG_W-1:0]     rt_mag_q [ROOT_STEPS], rt_mag_in [ROOT_STEPS];

  lav_tag_t                  ds_tag_q;
  logic [2:0][NUM_W-1:0]     ds_rem_q, ds_rem_d;
  logic [LEN_W-1:0]          ds_len_q, ds_len_d;

  lav_tag_t                  dv_tag_q [Q_W], dv_tag_in [Q_W];
  logic [2:0][NUM_W-1:0]     dv_rem_q [Q_W], dv_rem_in [Q_W], dv_rem_d [Q_W];
  logic [2:0][Q_W-1:0]       dv_quo_q [Q_W], dv_quo_in [Q_W], dv_quo_d [Q_W];
  logic [LEN_W-1:0]          dv_len_q [Q_W], dv_len_in [Q_W];
  logic [NUM_W:0]            dv_sub [Q_W];

  lav_tag_t                  fn_tag_q;
  lav_unit3_t                fn_unit_q, fn_unit_d;

  // stage 1: sign and magnitude
  always_comb begin
    s1_tag_d.vld  = valid_i;
    s1_tag_d.zero = 1'b0;
    s1_tag_d.pass = pass_i;
    for (int k = 0; k < 3; k++) begin
      s1_tag_d.neg[k] = vec_i[k][V_W-1];
      s1_mag_d[k]     = vec_i[k][V_W-1] ? (~vec_i[k] + 1'b1) : vec_i[k];
    end
  end

  // stage 2 input: common leading one
  assign s1_or = s1_mag_q[0] | s1_mag_q[1] | s1_mag_q[2];

  // stage 2 tag: zero vector flag
  always_comb begin
    s2_tag_d      = s1_tag_q;
    s2_tag_d.zero = (s1_or == '0);
  end

  // stage 3: scale so the largest magnitude has its top bit at MAG_W-1
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s2_pos_q > POS_W'(MAG_W - 1)) begin
        s3_mag_d[k] = MAG_W'(s2_mag_q[k] >> (s2_pos_q - POS_W'(MAG_W - 1)));
      end else begin
        s3_mag_d[k] = MAG_W'(s2_mag_q[k] << (POS_W'(MAG_W - 1) - s2_pos_q));
      end
    end
  end

  // square root, one result bit per stage
  always_comb begin
    rt_xin[0]    = s5_sum_q;
    rt_rin[0]    = '0;
    rt_tag_in[0] = s5_tag_q;
    rt_mag_in[0] = s5_mag_q;
    for (int k = 1; k < ROOT_STEPS; k++) begin
      rt_xin[k]    = rt_x_q[k-1];
      rt_rin[k]    = rt_r_q[k-1];
      rt_tag_in[k] = rt_tag_q[k-1];
      rt_mag_in[k] = rt_mag_q[k-1];
    end
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rt_trial[k] = {1'b0, rt_rin[k]} + ((SQ_W+1)'(1) << (SQ_W - 2 - 2 * k));
      if ({1'b0, rt_xin[k]} >= rt_trial[k]) begin
        rt_x_d[k] = rt_xin[k] - rt_trial[k][SQ_W-1:0];
        rt_r_d[k] = (rt_rin[k] >> 1) + (SQ_W'(1) << (SQ_W - 2 - 2 * k));
      end else begin
        rt_x_d[k] = rt_xin[k];
        rt_r_d[k] = rt_rin[k] >> 1;
      end
    end
  end

  // divide setup: scaled magnitude plus half the length
  always_comb begin
    ds_len_d = rt_r_q[ROOT_STEPS-1][LEN_W-1:0];
    for (int k = 0; k < 3; k++) begin
      ds_rem_d[k] = (NUM_W'(rt_mag_q[ROOT_STEPS-1][k]) << FRAC_BITS)
                    + NUM_W'(ds_len_d >> 1);
    end
  end

  // restoring divide, one quotient bit per stage in each lane
  always_comb begin
    dv_tag_in[0] = ds_tag_q;
    dv_rem_in[0] = ds_rem_q;
    dv_quo_in[0] = '0;
    dv_len_in[0] = ds_len_q;
    for (int j = 1; j < Q_W; j++) begin
      dv_tag_in[j] = dv_tag_q[j-1];
      dv_rem_in[j] = dv_rem_q[j-1];
      dv_quo_in[j] = dv_quo_q[j-1];
      dv_len_in[j] = dv_len_q[j-1];
    end
    for (int j = 0; j < Q_W; j++) begin
      dv_sub[j] = (NUM_W+1)'(dv_len_in[j]) << (Q_W - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if ({1'b0, dv_rem_in[j][k]} >= dv_sub[j]) begin
          dv_rem_d[j][k] = dv_rem_in[j][k] - dv_sub[j][NUM_W-1:0];
          dv_quo_d[j][k] = dv_quo_in[j][k] | (Q_W'(1) << (Q_W - 1 - j));
        end else begin
          dv_rem_d[j][k] = dv_rem_in[j][k];
          dv_quo_d[j][k] = dv_quo_in[j][k];
        end
      end
    end
  end

  // sign restore, zero vector gives zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_tag_q[Q_W-1].zero) begin
        fn_unit_d[k] = '0;
      end else if (dv_tag_q[Q_W-1].neg[k]) begin
        fn_unit_d[k] = ~U_W'(dv_quo_q[Q_W-1][k]) + 1'b1;
      end else begin
        fn_unit_d[k] = U_W'(dv_quo_q[Q_W-1][k]);
      end
    end
  end

  // item tags with valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
      s4_tag_q <= '0;
      s5_tag_q <= '0;
      ds_tag_q <= '0;
      fn_tag_q <= '0;
      for (int k = 0; k < ROOT_STEPS; k++) rt_tag_q[k] <= '0;
      for (int j = 0; j < Q_W; j++) dv_tag_q[j] <= '0;
    end else if (en_i) begin
      s1_tag_q      <= s1_tag_d;
      s2_tag_q      <= s2_tag_d;
      s3_tag_q      <= s2_tag_q;
      s4_tag_q      <= s3_tag_q;
      s5_tag_q      <= s4_tag_q;
      for (int k = 0; k < ROOT_STEPS; k++) rt_tag_q[k] <= rt_tag_in[k];
      ds_tag_q      <= rt_tag_q[ROOT_STEPS-1];
      for (int j = 0; j < Q_W; j++) dv_tag_q[j] <= dv_tag_in[j];
      fn_tag_q      <= dv_tag_q[Q_W-1];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mag_q <= s1_mag_d;
      s2_mag_q <= s1_mag_q;
      s2_pos_q <= lead_pos(s1_or);
      s3_mag_q <= s3_mag_d;
      s4_mag_q <= s3_mag_q;
      for (int k = 0; k < 3; k++) begin
        s4_sq_q[k] <= s3_mag_q[k] * s3_mag_q[k];
      end
      s5_mag_q <= s4_mag_q;
      s5_sum_q <= SQ_W'(s4_sq_q[0]) + SQ_W'(s4_sq_q[1]) + SQ_W'(s4_sq_q[2]);
      for (int k = 0; k < ROOT_STEPS; k++) begin
        rt_x_q[k]   <= rt_x_d[k];
        rt_r_q[k]   <= rt_r_d[k];
        rt_mag_q[k] <= rt_mag_in[k];
      end
      ds_rem_q <= ds_rem_d;
      ds_len_q <= ds_len_d;
      for (int j = 0; j < Q_W; j++) begin
        dv_rem_q[j] <= dv_rem_d[j];
        dv_quo_q[j] <= dv_quo_d[j];
        dv_len_q[j] <= dv_len_in[j];
      end
      fn_unit_q <= fn_unit_d;
    end
  end

  assign valid_o = fn_tag_q.vld;
  assign unit_o  = fn_unit_q;
  assign zero_o  = fn_tag_q.zero;
  assign pass_o  = fn_tag_q.pass;

endmodule

// ===== src/look_at_view_matrix_top.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Look-at view matrix in signed fixed point: forward, side and up vectors,
// translations, emitted as four row transfers per input item.
//
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+--------------------------------
// in      | input     | in_valid_i/in_ready_o | eye, target, upward (x, y, z)
// out     | output    | out_valid_o/out_ready_i | row_index, elem0..3, flags
//
// The output port carries one row per transfer.
// From input transfer to the first row an item passes through two normalize
// units of 56 stages each (32-stage square root, 17-stage divide) plus eight
// cross product, dot product and row stages.
// Reset clears valid bits, item tags and the row counter, not other data registers.
// A stalled output freezes the whole pipeline; the last stage holds the
// matrix until its fourth row transfers.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [lav_pkg::DATA_W-1:0] eye_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0] eye_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0] eye_z_i,
  input  logic signed [lav_pkg::DATA_W-1:0] target_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0] target_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0] target_z_i,
  input  logic signed [lav_pkg::DATA_W-1:0] upward_x_i,
  input  logic signed [lav_pkg::DATA_W-1:0] upward_y_i,
  input  logic signed [lav_pkg::DATA_W-1:0] upward_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        row_index_o,
  output logic signed [lav_pkg::DATA_W-1:0] elem0_o,
  output logic signed [lav_pkg::DATA_W-1:0] elem1_o,
  output logic signed [lav_pkg::DATA_W-1:0] elem2_o,
  output logic signed [lav_pkg::DATA_W-1:0] elem3_o,
  output logic                              degenerate_o,
  output logic                              last_row_o
);
  import lav_pkg::*;

  localparam int P2_W = $bits(lav_p2_t);

  logic adv;

  // forward normalize unit
  lav_vec3_t   u1_vec;
  lav_p1_t     u1_pin, u1_pout;
  logic [PASS_W-1:0] u1_pass;
  logic        u1_vld, u1_zero;
  lav_unit3_t  u1_unit;

  // side normalize unit
  lav_p2_t     u2_pin, u2_pout;
  logic [PASS_W-1:0] u2_pass;
  logic        u2_vld, u2_zero;
  lav_unit3_t  u2_unit;

  // cross product forward x upward
  logic                     c1_vld_q, c1_z_q;
  logic signed [UD_W-1:0]   c1_prod_q [6];
  logic signed [UD_W-1:0]   c1_prod_d [6];
  lav_unit3_t               c1_fwd_q;
  lav_data3_t               c1_eye_q;
  logic                     c2_vld_q, c2_z_q;
  lav_vec3_t                c2_sc_q;
  lav_unit3_t               c2_fwd_q;
  lav_data3_t               c2_eye_q;

  // up2 and translations
  logic                     d1_vld_q, d1_degen_q;
  logic signed [UU_W-1:0]   d1_uc_q [6];
  logic signed [UD_W-1:0]   d1_ps_q [3], d1_pf_q [3];
  lav_unit3_t               d1_side_q, d1_fwd_q;
  lav_data3_t               d1_eye_q;
  logic                     d2_vld_q, d2_degen_q;
  logic signed [DOT_W-1:0]  d2_uc_q [3];
  logic signed [DOT_W-1:0]  d2_ds_q, d2_df_q;
  lav_unit3_t               d2_side_q, d2_fwd_q;
  lav_data3_t               d2_eye_q;
  logic                     d3_vld_q, d3_degen_q;
  logic signed [U2_W-1:0]   d3_up2_q [3];
  logic signed [DOT_W-1:0]  d3_ts_q, d3_tf_q;
  lav_unit3_t               d3_side_q, d3_fwd_q;
  lav_data3_t               d3_eye_q;
  logic                     d4_vld_q, d4_degen_q;
  logic signed [U2D_W-1:0]  d4_pu_q [3];
  logic signed [U2_W-1:0]   d4_up2_q [3];
  logic signed [DOT_W-1:0]  d4_ts_q, d4_tf_q;
  lav_unit3_t               d4_side_q, d4_fwd_q;
  logic                     d5_vld_q, d5_degen_q;
  logic signed [DOT_W-1:0]  d5_du_q;
  logic signed [U2_W-1:0]   d5_up2_q [3];
  logic signed [DOT_W-1:0]  d5_ts_q, d5_tf_q;
  lav_unit3_t               d5_side_q, d5_fwd_q;

  // output hold stage
  logic                                 d6_vld_q, d6_degen_q;
  logic [3:0][3:0][DATA_W-1:0]          d6_rows_q, rows_d;
  logic signed [DOT_W-1:0]              tu;
  logic [1:0]                           row_q;

  // pipeline moves when the hold stage is empty or its last row transfers
  assign adv        = !d6_vld_q || (out_ready_i && (row_q == ROW_LAST));
  assign in_ready_o = adv;

  // direction and passengers into the forward unit
  assign u1_vec[0]  = V_W'(target_x_i) - V_W'(eye_x_i);
  assign u1_vec[1]  = V_W'(target_y_i) - V_W'(eye_y_i);
  assign u1_vec[2]  = V_W'(target_z_i) - V_W'(eye_z_i);
  assign u1_pin.eye = {eye_z_i, eye_y_i, eye_x_i};
  assign u1_pin.up  = {upward_z_i, upward_y_i, upward_x_i};

  lav_unit u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .vec_i   (u1_vec),
    .pass_i  (u1_pin),
    .valid_o (u1_vld),
    .unit_o  (u1_unit),
    .zero_o  (u1_zero),
    .pass_o  (u1_pass)
  );

  assign u1_pout = u1_pass;

  // cross product terms, forward x upward
  always_comb begin
    c1_prod_d[0] = mul_ud($signed(u1_unit[1]), $signed(u1_pout.up[2]));
    c1_prod_d[1] = mul_ud($signed(u1_unit[2]), $signed(u1_pout.up[1]));
    c1_prod_d[2] = mul_ud($signed(u1_unit[2]), $signed(u1_pout.up[0]));
    c1_prod_d[3] = mul_ud($signed(u1_unit[0]), $signed(u1_pout.up[2]));
    c1_prod_d[4] = mul_ud($signed(u1_unit[0]), $signed(u1_pout.up[1]));
    c1_prod_d[5] = mul_ud($signed(u1_unit[1]), $signed(u1_pout.up[0]));
  end

  assign u2_pin.z1  = c2_z_q;
  assign u2_pin.fwd = c2_fwd_q;
  assign u2_pin.eye = c2_eye_q;

  lav_unit u_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c2_vld_q),
    .vec_i   (c2_sc_q),
    .pass_i  (PASS_W'(u2_pin)),
    .valid_o (u2_vld),
    .unit_o  (u2_unit),
    .zero_o  (u2_zero),
    .pass_o  (u2_pass)
  );

  assign u2_pout = u2_pass[P2_W-1:0];

  // final rows with identity on a degenerate item
  always_comb begin
    tu = -shr_round(d5_du_q);
    for (int k = 0; k < 3; k++) begin
      rows_d[0][k] = DATA_W'($signed(d5_side_q[k]));
      rows_d[1][k] = DATA_W'(d5_up2_q[k]);
      rows_d[2][k] = DATA_W'(-$signed(d5_fwd_q[k]));
      rows_d[3][k] = '0;
    end
    rows_d[0][3] = sat_data(d5_ts_q);
    rows_d[1][3] = sat_data(tu);
    rows_d[2][3] = sat_data(d5_tf_q);
    rows_d[3][3] = ONE_Q;
    if (d5_degen_q) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          rows_d[r][c] = (r == c) ? ONE_Q : '0;
        end
      end
    end
  end

  // valid bits and row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
      d3_vld_q <= 1'b0;
      d4_vld_q <= 1'b0;
      d5_vld_q <= 1'b0;
      d6_vld_q <= 1'b0;
      row_q    <= ROW_FIRST;
    end else begin
      if (adv) begin
        c1_vld_q <= u1_vld;
        c2_vld_q <= c1_vld_q;
        d1_vld_q <= u2_vld;
        d2_vld_q <= d1_vld_q;
        d3_vld_q <= d2_vld_q;
        d4_vld_q <= d3_vld_q;
        d5_vld_q <= d4_vld_q;
        d6_vld_q <= d5_vld_q;
      end
      if (d6_vld_q && out_ready_i) begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // cross product of forward and upward
      c1_prod_q <= c1_prod_d;
      c1_fwd_q  <= u1_unit;
      c1_eye_q  <= u1_pout.eye;
      c1_z_q    <= u1_zero;
      for (int k = 0; k < 3; k++) begin
        c2_sc_q[k] <= V_W'(c1_prod_q[2*k]) - V_W'(c1_prod_q[2*k+1]);
      end
      c2_fwd_q <= c1_fwd_q;
      c2_eye_q <= c1_eye_q;
      c2_z_q   <= c1_z_q;

      // side x forward terms and dot products with eye
      d1_degen_q <= u2_pout.z1 | u2_zero;
      d1_uc_q[0] <= mul_uu($signed(u2_unit[1]), $signed(u2_pout.fwd[2]));
      d1_uc_q[1] <= mul_uu($signed(u2_unit[2]), $signed(u2_pout.fwd[1]));
      d1_uc_q[2] <= mul_uu($signed(u2_unit[2]), $signed(u2_pout.fwd[0]));
      d1_uc_q[3] <= mul_uu($signed(u2_unit[0]), $signed(u2_pout.fwd[2]));
      d1_uc_q[4] <= mul_uu($signed(u2_unit[0]), $signed(u2_pout.fwd[1]));
      d1_uc_q[5] <= mul_uu($signed(u2_unit[1]), $signed(u2_pout.fwd[0]));
      for (int k = 0; k < 3; k++) begin
        d1_ps_q[k] <= mul_ud($signed(u2_unit[k]), $signed(u2_pout.eye[k]));
        d1_pf_q[k] <= mul_ud($signed(u2_pout.fwd[k]), $signed(u2_pout.eye[k]));
      end
      d1_side_q <= u2_unit;
      d1_fwd_q  <= u2_pout.fwd;
      d1_eye_q  <= u2_pout.eye;

      // differences and sums
      d2_degen_q <= d1_degen_q;
      for (int k = 0; k < 3; k++) begin
        d2_uc_q[k] <= DOT_W'(d1_uc_q[2*k]) - DOT_W'(d1_uc_q[2*k+1]);
      end
      d2_ds_q   <= DOT_W'(d1_ps_q[0]) + DOT_W'(d1_ps_q[1]) + DOT_W'(d1_ps_q[2]);
      d2_df_q   <= DOT_W'(d1_pf_q[0]) + DOT_W'(d1_pf_q[1]) + DOT_W'(d1_pf_q[2]);
      d2_side_q <= d1_side_q;
      d2_fwd_q  <= d1_fwd_q;
      d2_eye_q  <= d1_eye_q;

      // rounding of up2 and two translations
      d3_degen_q <= d2_degen_q;
      for (int k = 0; k < 3; k++) begin
        d3_up2_q[k] <= U2_W'(shr_round(d2_uc_q[k]));
      end
      d3_ts_q   <= -shr_round(d2_ds_q);
      d3_tf_q   <= shr_round(d2_df_q);
      d3_side_q <= d2_side_q;
      d3_fwd_q  <= d2_fwd_q;
      d3_eye_q  <= d2_eye_q;

      // up2 dot eye terms
      d4_degen_q <= d3_degen_q;
      for (int k = 0; k < 3; k++) begin
        d4_pu_q[k] <= mul_u2d(d3_up2_q[k], $signed(d3_eye_q[k]));
      end
      d4_up2_q  <= d3_up2_q;
      d4_ts_q   <= d3_ts_q;
      d4_tf_q   <= d3_tf_q;
      d4_side_q <= d3_side_q;
      d4_fwd_q  <= d3_fwd_q;

      // up2 dot eye sum
      d5_degen_q <= d4_degen_q;
      d5_du_q    <= DOT_W'(d4_pu_q[0]) + DOT_W'(d4_pu_q[1]) + DOT_W'(d4_pu_q[2]);
      d5_up2_q   <= d4_up2_q;
      d5_ts_q    <= d4_ts_q;
      d5_tf_q    <= d4_tf_q;
      d5_side_q  <= d4_side_q;
      d5_fwd_q   <= d4_fwd_q;

      // matrix hold
      d6_degen_q <= d5_degen_q;
      d6_rows_q  <= rows_d;
    end
  end

  // row select
  assign out_valid_o  = d6_vld_q;
  assign row_index_o  = row_q;
  assign elem0_o      = d6_rows_q[row_q][0];
  assign elem1_o      = d6_rows_q[row_q][1];
  assign elem2_o      = d6_rows_q[row_q][2];
  assign elem3_o      = d6_rows_q[row_q][3];
  assign degenerate_o = d6_degen_q;
  assign last_row_o   = (row_q == ROW_LAST);

`ifndef SYNTHESIS
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (row_index_o != ROW_LAST)) |-> !in_ready_o)
    else $error("input taken while matrix rows still pending");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_row_o) |=> (row_index_o == ROW_FIRST))
    else $error("row counter did not return to first row");

  a_last_row_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_row_o) |-> ((elem3_o == ONE_Q) && (elem0_o == '0)))
    else $error("last row is not 0,0,0,1");

  a_degen_no_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o && !last_row_o) |-> (elem3_o == '0))
    else $error("degenerate matrix carries a translation");
`endif

endmodule
